// File: design/bud_pkg.sv
// package for the byte unstuffing deframer
// holds the framing constants, the phase enum and the result struct
// no dependencies
`default_nettype none

package bud_pkg;

  localparam logic [7:0]  StartByte    = 8'hff;
  localparam logic [7:0]  EscByte      = 8'hfd;
  localparam logic [7:0]  EscFfByte    = 8'hfe;
  localparam logic [15:0] HeaderLen    = 16'd3;
  localparam logic [15:0] MaxBytesRst  = 16'd65532;

  typedef enum logic [2:0] {
    PH_HUNT   = 3'd0,
    PH_LEN_HI = 3'd1,
    PH_LEN_LO = 3'd2,
    PH_BODY   = 3'd3,
    PH_ESC    = 3'd4
  } phase_e;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        frame_end;
    logic [15:0] delivered_count;
  } result_t;

endpackage

`default_nettype wire

// File: design/bud_in_reg.sv
// input register of the deframer
// holds one accepted rx byte until the decode step takes it; uses bud_pkg
`default_nettype none

module bud_in_reg
  import bud_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] rx_byte_i,
  input  wire logic       advance_i,
  output logic            hold_valid_o,
  output logic [7:0]      hold_byte_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q, byte_d;

  assign in_stall_o = valid_q && !advance_i;

  always_comb begin
    valid_d = valid_q;
    byte_d  = byte_q;
    if (!in_stall_o) begin
      valid_d = in_valid_i;
      if (in_valid_i) begin
        byte_d = rx_byte_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  assign hold_valid_o = valid_q;
  assign hold_byte_o  = byte_q;

endmodule

`default_nettype wire

// File: design/bud_decoder.sv
// framing state and single-pass unstuffing step
// updates phase, length and counters once per consumed byte; uses bud_pkg
`default_nettype none

module bud_decoder
  import bud_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        step_i,
  input  wire logic [7:0]  byte_i,
  input  wire logic [15:0] max_bytes_i,
  output logic             has_result_o,
  output result_t          result_o
);

  phase_e      phase_q, phase_d;
  logic [7:0]  len_hi_q, len_hi_d;
  logic [15:0] body_left_q, body_left_d;
  logic [15:0] delivered_q, delivered_d;

  logic [15:0] frame_len;
  logic        dlv;
  logic [7:0]  ob;
  logic        fend;
  logic        body_step;

  assign frame_len = {len_hi_q, byte_i};

  always_comb begin
    phase_d     = phase_q;
    len_hi_d    = len_hi_q;
    body_left_d = body_left_q;
    delivered_d = delivered_q;
    dlv         = 1'b0;
    ob          = 8'h00;
    fend        = 1'b0;
    body_step   = 1'b0;
    unique case (phase_q)
      PH_LEN_HI: begin
        len_hi_d = byte_i;
        phase_d  = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        delivered_d = '0;
        if (frame_len <= HeaderLen) begin
          body_left_d = '0;
          phase_d     = PH_HUNT;
          fend        = 1'b1;
        end else begin
          body_left_d = frame_len - HeaderLen;
          phase_d     = PH_BODY;
        end
      end
      PH_BODY: begin
        body_step = 1'b1;
        if (delivered_q < max_bytes_i) begin
          if (byte_i == EscByte) begin
            phase_d = PH_ESC;
          end else begin
            dlv = 1'b1;
            ob  = byte_i;
          end
        end
      end
      PH_ESC: begin
        body_step = 1'b1;
        phase_d   = PH_BODY;
        if (delivered_q < max_bytes_i) begin
          if (byte_i == EscFfByte) begin
            dlv = 1'b1;
            ob  = StartByte;
          end else if (byte_i == EscByte) begin
            dlv = 1'b1;
            ob  = EscByte;
          end
        end
      end
      default: begin
        phase_d = (byte_i == StartByte) ? PH_LEN_HI : PH_HUNT;
      end
    endcase

    // common tail of a body byte: count, length and frame end
    if (body_step) begin
      if (dlv) begin
        delivered_d = delivered_q + 16'd1;
      end
      if (body_left_q != '0) begin
        body_left_d = body_left_q - 16'd1;
      end
      fend = (body_left_d == '0);
      if (fend) begin
        phase_d = PH_HUNT;
      end
    end
  end

  assign has_result_o             = dlv || fend;
  assign result_o.out_byte        = ob;
  assign result_o.byte_valid      = dlv;
  assign result_o.frame_end       = fend;
  assign result_o.delivered_count = delivered_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HUNT;
      len_hi_q    <= '0;
      body_left_q <= '0;
      delivered_q <= '0;
    end else if (step_i) begin
      phase_q     <= phase_d;
      len_hi_q    <= len_hi_d;
      body_left_q <= body_left_d;
      delivered_q <= delivered_d;
    end
  end

endmodule

`default_nettype wire

// File: design/bud_out_reg.sv
// result register of the deframer
// keeps one result until the sink takes it; uses bud_pkg
`default_nettype none

module bud_out_reg
  import bud_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    load_i,
  input  wire result_t result_i,
  output logic         free_o,
  output logic         out_valid_o,
  input  wire logic    out_stall_i,
  output result_t      result_o
);

  logic    valid_q, valid_d;
  result_t res_q;

  assign free_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (free_o) begin
      valid_d = load_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && load_i) begin
      res_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = res_q;

endmodule

`default_nettype wire

// File: design/byte_unstuffing_deframer.sv
// byte unstuffing deframer: start byte hunt, 16-bit length header, escape removal
// an accepted byte is held in the input register, then its result is registered in the result register
// throughput: one rx byte per cycle while the sink does not stall, set by the single-pass decode
//   between the input register and the result register
// reset: asynchronous active low; phase to hunting, counters cleared, max_bytes 65532
// uses bud_pkg, bud_in_reg, bud_decoder, bud_out_reg
`default_nettype none

module byte_unstuffing_deframer
  import bud_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // max_bytes register write
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [15:0] cfg_max_bytes_i,
  // rx byte request
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  rx_byte_i,
  // result request
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       out_byte_o,
  output logic             byte_valid_o,
  output logic             frame_end_o,
  output logic [15:0]      delivered_count_o
);

  logic [15:0] max_bytes_q;
  logic        hold_valid;
  logic [7:0]  hold_byte;
  logic        out_free;
  logic        step;
  logic        has_result;
  result_t     step_res;
  result_t     out_res;

  // the register write is always taken
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_bytes_q <= MaxBytesRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      max_bytes_q <= cfg_max_bytes_i;
    end
  end

  // a held byte is decoded once the result register can take whatever it makes
  assign step = hold_valid && out_free;

  bud_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .rx_byte_i    (rx_byte_i),
    .advance_i    (out_free),
    .hold_valid_o (hold_valid),
    .hold_byte_o  (hold_byte)
  );

  bud_decoder u_decoder (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .byte_i       (hold_byte),
    .max_bytes_i  (max_bytes_q),
    .has_result_o (has_result),
    .result_o     (step_res)
  );

  // bytes that make no result (header, hunting, dropped) just leave the input register
  bud_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step && has_result),
    .result_i    (step_res),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (out_res)
  );

  assign out_byte_o        = out_res.out_byte;
  assign byte_valid_o      = out_res.byte_valid;
  assign frame_end_o       = out_res.frame_end;
  assign delivered_count_o = out_res.delivered_count;

endmodule

`default_nettype wire
